@@ design/rqs_pkg.sv @@
package rqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int PID_W      = 16;
	localparam int EST_W      = 24;
	localparam int LAST_W     = 16;
	localparam int RUN_W      = 8;
	localparam int ALPHA_W    = 9;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int AVG_SHIFT  = 8;
	localparam int PROD_W     = ALPHA_W + EST_W;
	localparam int ACC_W      = PROD_W + 1;

	localparam logic FIFO = 1'b0;
	localparam logic SRT  = 1'b1;

	localparam logic OP_ENQUEUE  = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_ENQUEUED   = 2'd0;
	localparam status_t ST_FULL       = 2'd1;
	localparam status_t ST_DISPATCHED = 2'd2;
	localparam status_t ST_NONE       = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_POLICY      = 2'd0;
	localparam cfg_idx_t CFG_ALPHA       = 2'd1;
	localparam cfg_idx_t CFG_MAX_RUNNING = 2'd2;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 9'd256;
	localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd128;
	localparam logic [RUN_W-1:0]   MAX_RUN_RST   = 8'd4;

	typedef struct packed {
		logic capture;
		logic mul_first;
		logic mul_second;
		logic sum;
		logic scan_rd;
		logic pick_load;
		logic shift_rd;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic op;
		logic recompute;
		logic disp_ok;
		logic scan_last;
		logic shift_more;
		logic out_free;
	} ctrl_sts_t;

endpackage

@@ design/rqs_ifs.sv @@
interface rqs_req_if;
	import rqs_pkg::*;
	logic              valid;
	logic              ready;
	logic              op;
	logic [PID_W-1:0]  pid;
	logic [EST_W-1:0]  estimate;
	logic [LAST_W-1:0] last_burst;
	logic              recompute;
	logic [RUN_W-1:0]  running;
	modport source(output valid, op, pid, estimate, last_burst, recompute, running,
		input ready);
	modport sink(input valid, op, pid, estimate, last_burst, recompute, running,
		output ready);
endinterface

interface rqs_rsp_if;
	import rqs_pkg::*;
	logic             valid;
	logic             ready;
	status_t          status;
	logic [PID_W-1:0] out_pid;
	logic [EST_W-1:0] out_estimate;
	modport source(output valid, status, out_pid, out_estimate, input ready);
	modport sink(input valid, status, out_pid, out_estimate, output ready);
endinterface

interface rqs_cfg_if;
	import rqs_pkg::*;
	logic                  valid;
	logic                  ready;
	cfg_idx_t              index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ design/rqs_ctrl.sv @@
module rqs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  rqs_pkg::ctrl_sts_t sts,
	output rqs_pkg::ctrl_cmd_t cmd
);
	import rqs_pkg::*;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DECIDE    = 4'd1;
	localparam logic [3:0] S_MUL1      = 4'd2;
	localparam logic [3:0] S_MUL2      = 4'd3;
	localparam logic [3:0] S_SUM       = 4'd4;
	localparam logic [3:0] S_SCAN      = 4'd5;
	localparam logic [3:0] S_SCAN_WAIT = 4'd6;
	localparam logic [3:0] S_PICK      = 4'd7;
	localparam logic [3:0] S_SHIFT     = 4'd8;
	localparam logic [3:0] S_DONE      = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.op == OP_ENQUEUE) begin
					state_d = sts.recompute ? S_MUL1 : S_DONE;
				end else begin
					state_d = sts.disp_ok ? S_SCAN : S_DONE;
				end
			end
			S_MUL1: begin
				cmd.mul_first = 1'b1;
				state_d       = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_second = 1'b1;
				state_d        = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_DONE;
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_SCAN_WAIT;
				end
			end
			S_SCAN_WAIT: begin
				state_d = S_PICK;
			end
			S_PICK: begin
				cmd.pick_load = 1'b1;
				state_d       = S_SHIFT;
			end
			S_SHIFT: begin
				if (sts.shift_more) begin
					cmd.shift_rd = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/rqs_datapath.sv @@
module rqs_datapath #(
	parameter int QUEUE_DEPTH = rqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_op,
	input  logic [rqs_pkg::PID_W-1:0]  req_pid,
	input  logic [rqs_pkg::EST_W-1:0]  req_estimate,
	input  logic [rqs_pkg::LAST_W-1:0] req_last_burst,
	input  logic                      req_recompute,
	input  logic [rqs_pkg::RUN_W-1:0]  req_running,
	rqs_rsp_if.source                 rsp,
	rqs_cfg_if.sink                   cfg,
	input  rqs_pkg::ctrl_cmd_t        cmd,
	output rqs_pkg::ctrl_sts_t        sts
);
	import rqs_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	// configuration
	logic               policy_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [RUN_W-1:0]   max_run_q;

	// captured item
	logic              op_q;
	logic              recompute_q;
	logic [PID_W-1:0]  pid_q;
	logic [EST_W-1:0]  est_q;
	logic [LAST_W-1:0] last_q;
	logic [RUN_W-1:0]  running_q;

	// queue state
	logic [PID_W-1:0] pid_mem [QUEUE_DEPTH];
	logic [EST_W-1:0] est_mem [QUEUE_DEPTH];
	logic [CW-1:0]    occ_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    pick_q;
	logic [PID_W-1:0] min_pid_q;
	logic [EST_W-1:0] min_est_q;
	logic [PID_W-1:0] rd_pid_q;
	logic [EST_W-1:0] rd_est_q;
	logic             scan_vld_s1;
	logic [CW-1:0]    scan_idx_s1;
	logic             shift_vld_s1;
	logic [AW-1:0]    wr_idx_s1;

	// averaging
	logic [PROD_W-1:0] prod_s1;
	logic [ACC_W-1:0]  acc_q;

	// result register
	logic             rsp_valid_q;
	status_t          rsp_status_q;
	logic [PID_W-1:0] rsp_pid_q;
	logic [EST_W-1:0] rsp_est_q;

	logic [ALPHA_W-1:0] alpha_sat;
	logic [ALPHA_W-1:0] mul_a;
	logic [EST_W-1:0]   mul_b;
	logic [PROD_W-1:0]  prod;
	logic [ACC_W-1:0]   avg_sum;
	logic               full;
	logic               disp_ok;
	logic               enq_ok;
	logic [CW-1:0]      scan_end;
	logic [CW-1:0]      idx_nxt;
	logic [AW-1:0]      rd_addr;
	logic               take;
	status_t            res_status;
	logic [PID_W-1:0]   res_pid;
	logic [EST_W-1:0]   res_est;

	assign alpha_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign mul_a     = cmd.mul_first ? alpha_sat : (ALPHA_ONE - alpha_sat);
	assign mul_b     = cmd.mul_first ? EST_W'(last_q) : est_q;
	assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign avg_sum   = acc_q + ACC_W'(prod_s1);

	assign full     = (occ_q == DEPTH_C);
	assign disp_ok  = (occ_q != '0) && (running_q < max_run_q);
	assign enq_ok   = (op_q == OP_ENQUEUE) && !full;
	assign scan_end = (policy_q == SRT) ? (occ_q - CW'(1)) : '0;
	assign idx_nxt  = idx_q + CW'(1);
	assign rd_addr  = cmd.scan_rd ? idx_q[AW-1:0] : idx_nxt[AW-1:0];
	assign take     = scan_vld_s1 && ((scan_idx_s1 == '0) || (rd_est_q < min_est_q));

	always_comb begin
		if (op_q == OP_ENQUEUE) begin
			res_status = full ? ST_FULL : ST_ENQUEUED;
			res_pid    = '0;
			res_est    = est_q;
		end else if (disp_ok) begin
			res_status = ST_DISPATCHED;
			res_pid    = min_pid_q;
			res_est    = min_est_q;
		end else begin
			res_status = ST_NONE;
			res_pid    = '0;
			res_est    = '0;
		end
	end

	assign sts.op         = op_q;
	assign sts.recompute  = recompute_q;
	assign sts.disp_ok    = disp_ok;
	assign sts.scan_last  = (idx_q == scan_end);
	assign sts.shift_more = (idx_nxt < occ_q);
	assign sts.out_free   = !rsp_valid_q || rsp.ready;

	assign cfg.ready        = 1'b1;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.out_pid      = rsp_pid_q;
	assign rsp.out_estimate = rsp_est_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= FIFO;
			alpha_q   <= ALPHA_RST;
			max_run_q <= MAX_RUN_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_POLICY:      policy_q  <= cfg.data[0];
				CFG_ALPHA:       alpha_q   <= cfg.data;
				CFG_MAX_RUNNING: max_run_q <= cfg.data[RUN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q        <= '0;
			scan_vld_s1  <= 1'b0;
			shift_vld_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			scan_vld_s1  <= cmd.scan_rd;
			shift_vld_s1 <= cmd.shift_rd;
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
				if (enq_ok) begin
					occ_q <= occ_q + CW'(1);
				end else if ((op_q == OP_DISPATCH) && disp_ok) begin
					occ_q <= occ_q - CW'(1);
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q        <= req_op;
			recompute_q <= req_recompute;
			pid_q       <= req_pid;
			est_q       <= req_estimate;
			last_q      <= req_last_burst;
			running_q   <= req_running;
		end else if (cmd.sum) begin
			est_q <= avg_sum[AVG_SHIFT +: EST_W];
		end

		if (cmd.mul_first || cmd.mul_second) begin
			prod_s1 <= prod;
		end
		if (cmd.mul_second) begin
			acc_q <= ACC_W'(prod_s1) << AVG_SHIFT;
		end

		if (cmd.capture) begin
			idx_q <= '0;
		end else if (cmd.pick_load) begin
			idx_q <= pick_q;
		end else if (cmd.scan_rd || cmd.shift_rd) begin
			idx_q <= idx_nxt;
		end

		scan_idx_s1 <= idx_q;
		wr_idx_s1   <= idx_q[AW-1:0];

		if (take) begin
			min_pid_q <= rd_pid_q;
			min_est_q <= rd_est_q;
			pick_q    <= scan_idx_s1;
		end

		if (cmd.finish) begin
			rsp_status_q <= res_status;
			rsp_pid_q    <= res_pid;
			rsp_est_q    <= res_est;
		end
	end

	// slot memory, one read and one write port
	always_ff @(posedge clk) begin
		if (cmd.scan_rd || cmd.shift_rd) begin
			rd_pid_q <= pid_mem[rd_addr];
			rd_est_q <= est_mem[rd_addr];
		end
		if (shift_vld_s1) begin
			pid_mem[wr_idx_s1] <= rd_pid_q;
			est_mem[wr_idx_s1] <= rd_est_q;
		end else if (cmd.finish && enq_ok) begin
			pid_mem[occ_q[AW-1:0]] <= pid_q;
			est_mem[occ_q[AW-1:0]] <= est_q;
		end
	end

endmodule

@@ design/ready_queue_fifo_srt_scheduler_core.sv @@
// channel | dir | handshake     | payload
// req     | in  | valid / ready | op, pid, estimate, last_burst, recompute, running
// rsp     | out | valid / ready | status, out_pid, out_estimate
// cfg     | in  | valid / ready | index, data (ready held high)
//
// one item at a time; enqueue passes a decide step, with recompute also two
// multiply steps and a sum, the two products sharing one 9x24 multiplier
// dispatch scans, then shifts later slots forward; the scan covers every slot
// under shortest estimate and only the head otherwise; one slot is read a cycle
// reset clears configuration, occupancy and handshake state; slots need no clearing
// a stalled rsp holds its result; a new req transfer is taken meanwhile
module ready_queue_fifo_srt_scheduler_core #(
	parameter int QUEUE_DEPTH = rqs_pkg::QUEUE_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rqs_req_if.sink   req,
	rqs_rsp_if.source rsp,
	rqs_cfg_if.sink   cfg
);
	import rqs_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	rqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rqs_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_op         (req.op),
		.req_pid        (req.pid),
		.req_estimate   (req.estimate),
		.req_last_burst (req.last_burst),
		.req_recompute  (req.recompute),
		.req_running    (req.running),
		.rsp            (rsp),
		.cfg            (cfg),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule

@@ design/rqs_checker.sv @@
module rqs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [rqs_pkg::STATUS_W-1:0] rsp_status,
	input logic [rqs_pkg::PID_W-1:0]    rsp_out_pid,
	input logic [rqs_pkg::EST_W-1:0]    rsp_out_estimate
);
	import rqs_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req ready right after a transfer");

	a_pid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_DISPATCHED) |-> rsp_out_pid == '0)
		else $error("pid reported without dispatch");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_NONE) |-> rsp_out_estimate == '0)
		else $error("estimate reported with nothing dispatched");

endmodule

bind ready_queue_fifo_srt_scheduler_core rqs_checker u_rqs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_out_pid      (rsp.out_pid),
	.rsp_out_estimate (rsp.out_estimate)
);
